>>> rtl/firsat_pkg.sv
package firsat_pkg;

  // Filter length and field widths
  localparam int TAPS     = 32;
  localparam int SAMPLE_W = 12;
  localparam int COEF_W   = 16;
  localparam int IDX_W    = 5;
  localparam int Q_SHIFT  = 15;

  // Tap counter indexes the delay line and coefficient table directly
  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  // Signed coefficient times zero-extended sample
  localparam int PROD_W = COEF_W + SAMPLE_W + 1;

  // Room for the sum over all taps
  localparam int ACC_W = PROD_W + CNT_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  // Request opcodes
  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

>>> rtl/fir_filter_saturating_12bit.sv
// Direct-form FIR filter over unsigned 12-bit samples with signed Q1.15 taps.
// Input channel (in_valid / in_stall): a request with in_opcode = OP_COEF stores
// in_coef_value at tap in_tap_index and gives no result; indexes at or above
// the filter length are dropped. A request with in_opcode = OP_SAMPLE shifts
// in_sample_in into the delay line (cleared first when in_block_start is set)
// and produces one filtered sample on the output channel.
// Output channel (out_valid / out_stall): out_sample_out is the dot product of
// taps and delay line, floored by 2^15 and clamped to 0..4095.
// Timing: one shared multiplier is stepped over the taps, one tap per cycle,
// followed by a final add (ST_DRAIN) and a clamp step (ST_FIN). in_stall is
// high from acceptance of a sample request until the sequencer is idle again,
// so no new request is taken before that sample's result is registered.
// Coefficient requests are taken every cycle while idle.
// Stall: the output register holds its result while out_stall is high; the
// block keeps accepting requests meanwhile, but a following sample holds in its
// clamp cycle until the output register is free.
// Reset (rst_n low, synchronous): coefficient table and delay line are cleared
// to zero, the sequencer goes idle and out_valid drops.
module fir_filter_saturating_12bit
  import firsat_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic [IDX_W-1:0]         in_tap_index,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic [SAMPLE_W-1:0]      in_sample_in,
  input  logic                     in_block_start,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SAMPLE_W-1:0]      out_sample_out
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [CNT_W-1:0] LAST_TAP = CNT_W'(TAPS - 1);

  logic [1:0]                state_r;
  logic [1:0]                state_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic [SAMPLE_W-1:0]       delay_r [TAPS];
  logic signed [COEF_W-1:0]  coef_r  [TAPS];
  logic signed [PROD_W-1:0]  prod_r;
  logic                      prod_vld_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      out_valid_r;
  logic [SAMPLE_W-1:0]       out_data_r;

  logic                      in_accept;
  logic                      out_free;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic [SAMPLE_W-1:0]       sat_val;
  logic                      acc_neg;
  logic                      acc_over;

  // Handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  // Shared multiplier: current tap times current delay entry
  assign prod_nxt = PROD_W'(coef_r[cnt_r] * $signed({1'b0, delay_r[cnt_r]}));

  // Floor by 2^15 then clamp to the sample range
  assign acc_neg  = acc_r[ACC_W-1];
  assign acc_over = |acc_r[ACC_W-2:Q_SHIFT+SAMPLE_W];
  always_comb begin
    if (acc_neg) begin
      sat_val = '0;
    end else if (acc_over) begin
      sat_val = SAMPLE_MAX;
    end else begin
      sat_val = acc_r[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_opcode == OP_SAMPLE) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt_r == LAST_TAP) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prod_vld_r <= (state_r == ST_MAC);
      if (state_r == ST_MAC) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Coefficient table and delay line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        coef_r[k]  <= '0;
        delay_r[k] <= '0;
      end
    end else if (in_accept) begin
      if (in_opcode == OP_COEF) begin
        if ({{(32-IDX_W){1'b0}}, in_tap_index} < 32'(TAPS)) begin
          coef_r[CNT_W'(in_tap_index)] <= in_coef_value;
        end
      end else begin
        delay_r[0] <= in_sample_in;
        for (int k = 1; k < TAPS; k++) begin
          delay_r[k] <= in_block_start ? '0 : delay_r[k-1];
        end
      end
    end
  end

  // Multiply-accumulate datapath
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (state_r == ST_IDLE) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_data_r <= sat_val;
    end
  end

endmodule
